// ===== hw/rtl/ibp_pkg.sv =====
// shared types and constants for the iq sample bit packer
`timescale 1ns / 1ps

package ibp_pkg;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned WIDTH_W     = 5;
  localparam int unsigned RES_W       = 7;
  localparam int unsigned RCNT_W      = 3;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned MAX_BYTES   = 3;
  localparam int unsigned NB_W        = 2;
  localparam int unsigned ACC_W       = RES_W + SAMPLE_W;
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned PDATA_W     = 32;
  localparam int unsigned PADDR_W     = 3;

  localparam logic [WIDTH_W-1:0] WIDTH_MAX   = 5'd16;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 5'd9;
  localparam logic [BYTE_W-1:0]  BYTE_MASK   = 8'hff;

  // register index, taken from the word address bit
  typedef enum logic [0:0] {
    REG_SAMPLE_WIDTH = 1'b0
  } reg_idx_t;

  // bytes produced by one sample, oldest in slot 0
  typedef struct packed {
    logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
    logic [NB_W-1:0]                  num;
  } pack_res_t;

endpackage

// ===== hw/rtl/ibp_cfg.sv =====
// configuration register block with apb-style access
`timescale 1ns / 1ps

module ibp_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ibp_pkg::PADDR_W-1:0] paddr,
  input  logic [ibp_pkg::PDATA_W-1:0] pwdata,
  output logic [ibp_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output logic [ibp_pkg::WIDTH_W-1:0] sample_width
);
  import ibp_pkg::*;

  logic [WIDTH_W-1:0] width_r;
  logic [WIDTH_W-1:0] width_nxt;
  reg_idx_t           idx;
  logic               idx_hit;

  // word index: bit 2 selects the register, low bits are byte lanes
  assign idx     = reg_idx_t'(paddr[2]);
  assign idx_hit = (idx == REG_SAMPLE_WIDTH);

  // register write on the access phase
  always_comb begin
    width_nxt = width_r;
    if (psel && penable && pwrite && idx_hit) begin
      width_nxt = pwdata[WIDTH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_RESET;
    end else begin
      width_r <= width_nxt;
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    if (idx_hit) begin
      prdata = {{(PDATA_W-WIDTH_W){1'b0}}, width_r};
    end
  end

  assign pready       = 1'b1;
  assign sample_width = width_r;

endmodule

// ===== hw/rtl/ibp_pack.sv =====
// combinational bit packing of one sample against the held residue
`timescale 1ns / 1ps

module ibp_pack (
  input  logic [ibp_pkg::SAMPLE_W-1:0] sample,
  input  logic                         final_flag,
  input  logic [ibp_pkg::WIDTH_W-1:0]  width,
  input  logic [ibp_pkg::RES_W-1:0]    res_bits,
  input  logic [ibp_pkg::RCNT_W-1:0]   res_cnt,
  output ibp_pkg::pack_res_t           res,
  output logic [ibp_pkg::RES_W-1:0]    res_bits_nxt,
  output logic [ibp_pkg::RCNT_W-1:0]   res_cnt_nxt
);
  import ibp_pkg::*;

  logic [WIDTH_W-1:0]        w;
  logic [SAMPLE_W:0]         smask;
  logic [SAMPLE_W-1:0]       sbits;
  logic [ACC_W-1:0]          acc;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          sh0;
  logic [CNT_W-1:0]          sh1;
  logic [NB_W-1:0]           nfull;
  logic [RCNT_W-1:0]         rem;
  logic [RCNT_W:0]           pad_sh;
  logic [ACC_W+BYTE_W-1:0]   pad_wide;
  logic [BYTE_W-1:0]         byte0;
  logic [BYTE_W-1:0]         byte1;
  logic [BYTE_W-1:0]         pad;
  logic                      pad_en;
  logic [RES_W-1:0]          rmask;

  // widths above sixteen saturate
  assign w = (width > WIDTH_MAX) ? WIDTH_MAX : width;

  // keep low w bits of the sample and append them below the residue
  assign smask = (17'(1) << w) - 17'(1);
  assign sbits = sample & smask[SAMPLE_W-1:0];
  assign acc   = ({{SAMPLE_W{1'b0}}, res_bits} << w) | {{RES_W{1'b0}}, sbits};
  assign count = {2'b00, res_cnt} + w;

  assign nfull = count[CNT_W-1:RCNT_W];
  assign rem   = count[RCNT_W-1:0];

  // full bytes, oldest bits first
  assign sh0   = count - 5'd8;
  assign sh1   = count - 5'd16;
  assign byte0 = BYTE_W'(acc >> sh0) & BYTE_MASK;
  assign byte1 = BYTE_W'(acc >> sh1) & BYTE_MASK;

  // tail byte: leftover bits moved to the top, zeros below
  assign pad_sh   = 4'd8 - {1'b0, rem};
  assign pad_wide = {{BYTE_W{1'b0}}, acc} << pad_sh;
  assign pad      = pad_wide[BYTE_W-1:0];
  assign pad_en   = final_flag && (rem != '0);

  // slot assembly: full bytes first, padded byte after them
  always_comb begin
    res.bytes[0] = (nfull != 2'd0) ? byte0 : pad;
    res.bytes[1] = (nfull == 2'd2) ? byte1 : pad;
    res.bytes[2] = pad;
    res.num      = nfull + NB_W'(pad_en);
  end

  // residue update, cleared at the end of a block
  assign rmask        = (7'(1) << rem) - 7'(1);
  assign res_bits_nxt = final_flag ? '0 : (acc[RES_W-1:0] & rmask);
  assign res_cnt_nxt  = final_flag ? '0 : rem;

endmodule

// ===== hw/rtl/ibp_obuf.sv =====
// result register that hands out the bytes of one sample one beat at a time
`timescale 1ns / 1ps

module ibp_obuf (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  ibp_pkg::pack_res_t            res,
  output logic                          free,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ibp_pkg::BYTE_W-1:0]    out_packed_byte,
  output logic                          out_byte_last
);
  import ibp_pkg::*;

  logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes_r;
  logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes_nxt;
  logic [NB_W-1:0]                  cnt_r;
  logic [NB_W-1:0]                  cnt_nxt;
  logic                             take;

  assign out_valid       = (cnt_r != '0);
  assign take            = out_valid && out_ready;
  assign out_packed_byte = bytes_r[0];
  assign out_byte_last   = (cnt_r == 2'd1);

  // room for a new sample once the last byte leaves
  assign free = (cnt_r == '0) || (out_byte_last && out_ready);

  // shift on each beat, load when a sample is packed
  always_comb begin
    bytes_nxt = bytes_r;
    cnt_nxt   = cnt_r;
    if (take) begin
      bytes_nxt[0] = bytes_r[1];
      bytes_nxt[1] = bytes_r[2];
      cnt_nxt      = cnt_r - 2'd1;
    end
    if (load && (res.num != '0)) begin
      bytes_nxt = res.bytes;
      cnt_nxt   = res.num;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    bytes_r <= bytes_nxt;
  end

endmodule

// ===== hw/rtl/iq_sample_bit_packer.sv =====
// top level of the iq sample bit packer
`timescale 1ns / 1ps

// Packs the low sample_width bits (1..16, larger values act as 16, reset 9)
// of each IQ sample MSB first into a byte stream; a sample flagged final
// flushes a partial byte padded with zeros. A sample is held in the input
// register and packed in one pass against the held residue. While
// out_ready is high, its 0 to 3 bytes leave from the result register one
// beat per cycle, and a new sample is taken every cycle as long as each
// makes at most one byte; a sample that makes more holds the packer until
// its last byte leaves, since the output port carries one byte per cycle.
// sample_width is written over the register port at byte address 0 and
// should only change while no sample is in flight.
module iq_sample_bit_packer (
  input  logic                          clk,
  input  logic                          rst_n,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ibp_pkg::PADDR_W-1:0]   paddr,
  input  logic [ibp_pkg::PDATA_W-1:0]   pwdata,
  output logic [ibp_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  // sample input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [ibp_pkg::SAMPLE_W-1:0] in_iq_sample,
  input  logic                          in_is_final,
  // byte output
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ibp_pkg::BYTE_W-1:0]    out_packed_byte,
  output logic                          out_byte_last
);
  import ibp_pkg::*;

  logic [WIDTH_W-1:0]  sample_width;
  logic                vld_r;
  logic                vld_nxt;
  logic [SAMPLE_W-1:0] sample_r;
  logic                final_r;
  logic [RES_W-1:0]    res_bits_r;
  logic [RES_W-1:0]    res_bits_nxt;
  logic [RCNT_W-1:0]   res_cnt_r;
  logic [RCNT_W-1:0]   res_cnt_nxt;
  pack_res_t           pres;
  logic                obuf_free;
  logic                pack_fire;
  logic                in_take;

  ibp_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample_width (sample_width)
  );

  // input register handshake
  assign pack_fire = vld_r && obuf_free;
  assign in_ready  = !vld_r || pack_fire;
  assign in_take   = in_valid && in_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (pack_fire) begin
      vld_nxt = 1'b0;
    end
    if (in_take) begin
      vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (in_take) begin
      sample_r <= in_iq_sample;
      final_r  <= in_is_final;
    end
  end

  ibp_pack u_pack (
    .sample       (sample_r),
    .final_flag   (final_r),
    .width        (sample_width),
    .res_bits     (res_bits_r),
    .res_cnt      (res_cnt_r),
    .res          (pres),
    .res_bits_nxt (res_bits_nxt),
    .res_cnt_nxt  (res_cnt_nxt)
  );

  // residue advances once per packed sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_bits_r <= '0;
      res_cnt_r  <= '0;
    end else if (pack_fire) begin
      res_bits_r <= res_bits_nxt;
      res_cnt_r  <= res_cnt_nxt;
    end
  end

  ibp_obuf u_obuf (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (pack_fire),
    .res             (pres),
    .free            (obuf_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_packed_byte (out_packed_byte),
    .out_byte_last   (out_byte_last)
  );

endmodule

// ===== hw/rtl/ibp_checker.sv =====
// port-level checks for the iq sample bit packer, bound to the top level
`timescale 1ns / 1ps

module ibp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [ibp_pkg::PADDR_W-1:0]   paddr,
  input logic [ibp_pkg::PDATA_W-1:0]   pwdata,
  input logic [ibp_pkg::PDATA_W-1:0]   prdata,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ibp_pkg::BYTE_W-1:0]    out_packed_byte,
  input logic                          out_byte_last
);
  import ibp_pkg::*;

  // a stalled output beat keeps its byte and flag
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && out_valid && !out_ready) |=>
      (out_valid && $stable(out_packed_byte) && $stable(out_byte_last)))
    else $error("output beat changed while stalled");

  // an input beat stays offered until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && in_valid && !in_ready) |=> in_valid)
    else $error("input valid dropped before accept");

  // bytes of one sample leave back to back, no gap before the last one
  a_out_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && out_valid && out_ready && !out_byte_last) |=> out_valid)
    else $error("gap inside the bytes of one sample");

  // a width write reads back on the next cycle
  a_width_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && psel && penable && pwrite && (paddr[2] == REG_SAMPLE_WIDTH)) |=>
      (prdata[WIDTH_W-1:0] == $past(pwdata[WIDTH_W-1:0]) || paddr[2] != REG_SAMPLE_WIDTH))
    else $error("sample width readback mismatch");

endmodule

bind iq_sample_bit_packer ibp_checker u_ibp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .psel            (psel),
  .penable         (penable),
  .pwrite          (pwrite),
  .paddr           (paddr),
  .pwdata          (pwdata),
  .prdata          (prdata),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_packed_byte (out_packed_byte),
  .out_byte_last   (out_byte_last)
);
